// ===== hdl/soifp_pkg.sv =====
package soifp_pkg;

  localparam int unsigned OFF_W  = 25;
  localparam int unsigned NAME_W = 7;
  localparam int unsigned LEN_W  = 29;

  localparam logic [OFF_W-1:0]  MAX_RECORD_BYTES = 25'h1000000;
  localparam logic [NAME_W-1:0] MAX_NAME_LEN     = 7'd127;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    MODE_LINE,
    MODE_HEAD,
    MODE_NAME,
    MODE_LEN0,
    MODE_LEN,
    MODE_COLON,
    MODE_TAB,
    MODE_VALUE,
    MODE_URL,
    MODE_IGNORE
  } mode_e;

  typedef enum logic [1:0] {
    EV_FIELD    = 2'd0,
    EV_COMPLETE = 2'd1,
    EV_ERROR    = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_URL_NL   = 2'd1,
    ERR_BAD_LINE = 2'd2,
    ERR_VALUE_NL = 2'd3
  } err_e;

  typedef struct packed {
    mode_e             mode;
    logic [OFF_W-1:0]  offset;
    logic [3:0]        prefix_cnt;
    logic [OFF_W-1:0]  name_begin;
    logic [NAME_W-1:0] name_cnt;
    logic              brace_only;
    logic [OFF_W-1:0]  remaining;
    logic [OFF_W-1:0]  value_begin;
  } state_t;

  typedef struct packed {
    event_e            ev;
    err_e              err;
    logic              is_url;
    logic [OFF_W-1:0]  name_start;
    logic [NAME_W-1:0] name_length;
    logic [OFF_W-1:0]  value_start;
    logic [OFF_W-1:0]  value_end;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } res_set_t;

  function automatic logic [7:0] url_prefix(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h40;
      3'd1:    c = 8'h46;
      3'd2:    c = 8'h49;
      3'd3:    c = 8'h4C;
      3'd4:    c = 8'h45;
      3'd5:    c = 8'h20;
      3'd6:    c = 8'h7B;
      3'd7:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/soifp_step.sv =====
module soifp_step (
  input  soifp_pkg::state_t   state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output soifp_pkg::state_t   state_o,
  output soifp_pkg::res_set_t res_o
);

  typedef struct packed {
    logic                         done;
    logic                         fail;
    logic                         complete;
    soifp_pkg::mode_e             mode;
    logic [soifp_pkg::NAME_W-1:0] name_cnt;
    logic                         brace_only;
    logic                         clear_len;
  } nb_t;

  function automatic soifp_pkg::res_set_t push(input soifp_pkg::res_set_t acc,
                                               input soifp_pkg::result_t x);
    soifp_pkg::res_set_t r;
    r = acc;
    if (acc.count == 2'd0) begin
      r.r0    = x;
      r.count = 2'd1;
    end else if (acc.count == 2'd1) begin
      r.r1    = x;
      r.count = 2'd2;
    end
    return r;
  endfunction

  function automatic soifp_pkg::result_t mk_fail(input soifp_pkg::err_e code);
    soifp_pkg::result_t r;
    r        = '0;
    r.ev     = soifp_pkg::EV_ERROR;
    r.err    = code;
    return r;
  endfunction

  function automatic soifp_pkg::result_t mk_complete();
    soifp_pkg::result_t r;
    r     = '0;
    r.ev  = soifp_pkg::EV_COMPLETE;
    r.err = soifp_pkg::ERR_NONE;
    return r;
  endfunction

  // One byte on the name path of a named line.
  function automatic nb_t name_step(input logic [7:0] b, input logic last,
                                    input logic [soifp_pkg::NAME_W-1:0] nc,
                                    input logic brace, input soifp_pkg::mode_e mode);
    nb_t r;
    logic name_char;
    name_char = (b != soifp_pkg::CH_LBRACE) && (b != soifp_pkg::CH_COLON) &&
                (b != soifp_pkg::CH_NL) && (b != soifp_pkg::CH_SPACE) &&
                (b != soifp_pkg::CH_TAB);
    r.done       = 1'b0;
    r.fail       = 1'b0;
    r.complete   = 1'b0;
    r.mode       = mode;
    r.name_cnt   = nc;
    r.brace_only = brace;
    r.clear_len  = 1'b0;
    if (name_char) begin
      if (nc >= soifp_pkg::MAX_NAME_LEN) begin
        r.fail = 1'b1;
        r.done = 1'b1;
      end else begin
        r.name_cnt   = nc + 1'b1;
        r.brace_only = (nc == '0) && (b == soifp_pkg::CH_RBRACE);
        r.mode       = soifp_pkg::MODE_NAME;
      end
    end else if (b == soifp_pkg::CH_LBRACE && nc != '0) begin
      r.mode      = soifp_pkg::MODE_LEN0;
      r.clear_len = 1'b1;
    end else if (b == soifp_pkg::CH_NL && brace && last) begin
      r.complete = 1'b1;
      r.done     = 1'b1;
    end else begin
      r.fail = 1'b1;
      r.done = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    soifp_pkg::state_t          s;
    soifp_pkg::res_set_t        res;
    soifp_pkg::result_t         fld;
    nb_t                        nb;
    logic                       done;
    logic                       use_nb;
    logic [2:0]                 k;
    logic [soifp_pkg::LEN_W-1:0] len_x;
    logic [soifp_pkg::OFF_W-1:0] off;

    s      = state_i;
    res    = '0;
    fld    = '0;
    done   = 1'b0;
    use_nb = 1'b0;
    off    = state_i.offset;
    k      = state_i.prefix_cnt[2:0];
    len_x  = '0;
    nb     = '0;

    if (state_i.mode == soifp_pkg::MODE_IGNORE) begin
      done = 1'b1;
    end else if (off >= soifp_pkg::MAX_RECORD_BYTES) begin
      res  = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
      done = 1'b1;
    end else begin
      case (state_i.mode)
        soifp_pkg::MODE_LINE: begin
          s.name_begin = off;
          s.name_cnt   = '0;
          s.brace_only = 1'b0;
          s.prefix_cnt = '0;
          if (byte_i == soifp_pkg::CH_AT) begin
            s.prefix_cnt = 4'd1;
            s.name_cnt   = 7'd1;
            s.mode       = soifp_pkg::MODE_HEAD;
          end else begin
            use_nb = 1'b1;
          end
        end
        soifp_pkg::MODE_HEAD: begin
          if (byte_i == soifp_pkg::url_prefix(k)) begin
            if (k < 3'd5) begin
              s.name_cnt = state_i.name_cnt + 1'b1;
            end
            if (k == 3'd7) begin
              s.prefix_cnt  = 4'd8;
              s.value_begin = off + 1'b1;
              s.mode        = soifp_pkg::MODE_URL;
            end else begin
              s.prefix_cnt = {1'b0, k} + 4'd1;
            end
          end else if (k >= 3'd6) begin
            res  = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
            done = 1'b1;
          end else begin
            s.mode = soifp_pkg::MODE_NAME;
            use_nb = 1'b1;
          end
        end
        soifp_pkg::MODE_NAME: begin
          use_nb = 1'b1;
        end
        soifp_pkg::MODE_LEN0, soifp_pkg::MODE_LEN: begin
          if (byte_i >= soifp_pkg::CH_ZERO && byte_i <= soifp_pkg::CH_NINE) begin
            len_x = ({4'd0, state_i.remaining} << 3) + ({4'd0, state_i.remaining} << 1) +
                    {21'd0, byte_i - soifp_pkg::CH_ZERO};
            if (len_x > {4'd0, soifp_pkg::MAX_RECORD_BYTES}) begin
              s.remaining = soifp_pkg::MAX_RECORD_BYTES;
            end else begin
              s.remaining = len_x[soifp_pkg::OFF_W-1:0];
            end
            s.mode = soifp_pkg::MODE_LEN;
          end else if (byte_i == soifp_pkg::CH_RBRACE &&
                       state_i.mode == soifp_pkg::MODE_LEN) begin
            s.mode = soifp_pkg::MODE_COLON;
          end else begin
            res  = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
            done = 1'b1;
          end
        end
        soifp_pkg::MODE_COLON: begin
          if (byte_i == soifp_pkg::CH_COLON) begin
            s.mode = soifp_pkg::MODE_TAB;
          end else begin
            res  = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
            done = 1'b1;
          end
        end
        soifp_pkg::MODE_TAB: begin
          if (byte_i == soifp_pkg::CH_TAB) begin
            s.value_begin = off + 1'b1;
            s.mode        = soifp_pkg::MODE_VALUE;
          end else begin
            res  = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
            done = 1'b1;
          end
        end
        soifp_pkg::MODE_VALUE: begin
          if (state_i.remaining == '0) begin
            fld             = '0;
            fld.ev          = soifp_pkg::EV_FIELD;
            fld.err         = soifp_pkg::ERR_NONE;
            fld.name_start  = state_i.name_begin;
            fld.name_length = state_i.name_cnt;
            fld.value_start = state_i.value_begin;
            fld.value_end   = off;
            res = push(res, fld);
            if (byte_i == soifp_pkg::CH_NL) begin
              s.mode = soifp_pkg::MODE_LINE;
            end else begin
              res  = push(res, mk_fail(soifp_pkg::ERR_VALUE_NL));
              done = 1'b1;
            end
          end else begin
            s.remaining = state_i.remaining - 1'b1;
          end
        end
        soifp_pkg::MODE_URL: begin
          if (byte_i == soifp_pkg::CH_NL) begin
            fld             = '0;
            fld.ev          = soifp_pkg::EV_FIELD;
            fld.err         = soifp_pkg::ERR_NONE;
            fld.is_url      = 1'b1;
            fld.value_start = state_i.value_begin;
            fld.value_end   = off;
            res    = push(res, fld);
            s.mode = soifp_pkg::MODE_LINE;
          end
        end
        default: begin
          res  = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
          done = 1'b1;
        end
      endcase

      if (use_nb) begin
        nb           = name_step(byte_i, last_i, s.name_cnt, s.brace_only, s.mode);
        s.mode       = nb.mode;
        s.name_cnt   = nb.name_cnt;
        s.brace_only = nb.brace_only;
        if (nb.clear_len) begin
          s.remaining = '0;
        end
        if (nb.fail) begin
          res = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
        end
        if (nb.complete) begin
          res = push(res, mk_complete());
        end
        done = nb.done;
      end
    end

    if (!done && last_i) begin
      if (s.mode == soifp_pkg::MODE_LINE) begin
        res = push(res, mk_complete());
      end else if (s.mode == soifp_pkg::MODE_URL) begin
        res = push(res, mk_fail(soifp_pkg::ERR_URL_NL));
      end else if (s.mode == soifp_pkg::MODE_VALUE && s.remaining == '0) begin
        fld             = '0;
        fld.ev          = soifp_pkg::EV_FIELD;
        fld.err         = soifp_pkg::ERR_NONE;
        fld.name_start  = s.name_begin;
        fld.name_length = s.name_cnt;
        fld.value_start = s.value_begin;
        fld.value_end   = off + 1'b1;
        res = push(res, fld);
        res = push(res, mk_fail(soifp_pkg::ERR_VALUE_NL));
      end else begin
        res = push(res, mk_fail(soifp_pkg::ERR_BAD_LINE));
      end
    end

    if (last_i) begin
      s      = '0;
      s.mode = soifp_pkg::MODE_LINE;
    end else begin
      if (done) begin
        s.mode = soifp_pkg::MODE_IGNORE;
      end
      if (off < soifp_pkg::MAX_RECORD_BYTES) begin
        s.offset = off + 1'b1;
      end
    end

    state_o = s;
    res_o   = res;
  end

endmodule

// ===== hdl/soif_record_field_parser.sv =====
// Channel  | Direction | tdata (low bit up)                        | tuser              | tlast
// s_axis   | in        | data_byte                                 | -                  | last_byte
// m_axis   | out       | error_code, name_start, name_length,      | event_res, is_url  | run_last
//          |           | value_start, value_end, zero pad          |                    |
// Each accepted beat updates the parser state in the same cycle and writes its zero, one or two
// results into a four-entry output queue; one result leaves per cycle while m_axis_tready is high.
// A new beat is taken every cycle while the queue has room for two results, so the sustained
// rate is one beat per cycle unless beats with two results outpace the output side.
// Reset (rst_ni low, asynchronous) returns the parser to the start of a record and empties
// the queue. A stall on m_axis holds the head result and backs up into s_axis tready.
module soif_record_field_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // error_code, name_start, name_length, value_start,
                                     // value_end, zero pad
  output logic [2:0]  m_axis_tuser,  // event_res, is_url
  output logic        m_axis_tlast
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    soifp_pkg::result_t res;
    logic               run_last;
  } qent_t;

  soifp_pkg::state_t   st_q, st_d;
  soifp_pkg::res_set_t step_res;
  qent_t               q_mem [QDepth];
  logic [QAw-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [QAw:0]        cnt_q, cnt_d;
  logic                in_acc, out_acc;
  logic [1:0]          n_wr;
  qent_t               head;

  soifp_step u_step (
    .state_i (st_q),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .state_o (st_d),
    .res_o   (step_res)
  );

  assign s_axis_tready = (cnt_q <= (QAw+1)'(QDepth - 2));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign n_wr          = in_acc ? step_res.count : 2'd0;

  assign wp_d  = wp_q + QAw'(n_wr);
  assign rp_d  = rp_q + QAw'(out_acc);
  assign cnt_d = cnt_q + (QAw+1)'(n_wr) - (QAw+1)'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{mode: soifp_pkg::MODE_LINE, default: '0};
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && step_res.count != 2'd0) begin
      q_mem[wp_q] <= '{res: step_res.r0, run_last: (step_res.count == 2'd1)};
    end
    if (in_acc && step_res.count == 2'd2) begin
      q_mem[wp_q + 1'b1] <= '{res: step_res.r1, run_last: 1'b1};
    end
  end

  assign head          = q_mem[rp_q];
  assign m_axis_tdata  = {4'd0, head.res.value_end, head.res.value_start,
                          head.res.name_length, head.res.name_start, head.res.err};
  assign m_axis_tuser  = {head.res.is_url, head.res.ev};
  assign m_axis_tlast  = head.run_last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAw+1)'(QDepth))
    else $error("output queue overfilled");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (st_q.mode == soifp_pkg::MODE_LINE && st_q.offset == '0))
    else $error("record end did not restart the parser");

  a_ignore_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.mode == soifp_pkg::MODE_IGNORE) |-> (st_q.offset != '0))
    else $error("ignore mode at record start");

  a_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("second result of a beat missing");

endmodule

// ===== dv/tb_soif_record_field_parser.sv =====
module tb_soif_record_field_parser;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_BYTES   = 850;
  localparam logic [63:0] URL_HEAD       = "@FILE { ";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } rec_byte_t;

  typedef struct packed {
    soifp_pkg::result_t res;
    logic               run_last;
  } parse_out_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rec_byte_t          record_bytes_q[$];
  parse_out_t         field_events_q[$];
  soifp_pkg::result_t step_events[$];
  logic       pause_pending = 1'b0;
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  logic       quiet = 1'b0;
  logic       draining = 1'b0;

  string field_tag [8] = '{"event_res", "error_code", "is_url", "name_start",
                           "name_length", "value_start", "value_end", "run_last"};

  soifp_pkg::mode_e                       p_mode;
  logic [soifp_pkg::OFF_W-1:0]  p_offset;
  logic [3:0]                   p_prefix;
  logic [soifp_pkg::OFF_W-1:0]  p_name_begin;
  logic [soifp_pkg::NAME_W-1:0] p_name_cnt;
  logic                         p_brace_only;
  logic [soifp_pkg::OFF_W-1:0]  p_remaining;
  logic [soifp_pkg::OFF_W-1:0]  p_value_begin;

  soif_record_field_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_parser();
    p_mode        = soifp_pkg::MODE_LINE;
    p_offset      = '0;
    p_prefix      = '0;
    p_name_begin  = '0;
    p_name_cnt    = '0;
    p_brace_only  = 1'b0;
    p_remaining   = '0;
    p_value_begin = '0;
  endtask

  task automatic add_event(input soifp_pkg::event_e ev, input soifp_pkg::err_e err,
                           input logic url,
                           input logic [soifp_pkg::OFF_W-1:0] ns,
                           input logic [soifp_pkg::NAME_W-1:0] nl,
                           input logic [soifp_pkg::OFF_W-1:0] vs,
                           input logic [soifp_pkg::OFF_W-1:0] ve);
    soifp_pkg::result_t r;
    r.ev          = ev;
    r.err         = err;
    r.is_url      = url;
    r.name_start  = ns;
    r.name_length = nl;
    r.value_start = vs;
    r.value_end   = ve;
    if (step_events.size() < 2) step_events.push_back(r);
  endtask

  task automatic add_error(input soifp_pkg::err_e err);
    add_event(soifp_pkg::EV_ERROR, err, 1'b0, '0, '0, '0, '0);
  endtask

  task automatic add_named_field(input logic [soifp_pkg::OFF_W-1:0] vend);
    add_event(soifp_pkg::EV_FIELD, soifp_pkg::ERR_NONE, 1'b0, p_name_begin, p_name_cnt,
              p_value_begin, vend);
  endtask

  task automatic name_step(input logic [7:0] b, input logic last, output logic fin);
    fin = 1'b1;
    if (b != soifp_pkg::CH_LBRACE && b != soifp_pkg::CH_COLON && b != soifp_pkg::CH_NL &&
        b != soifp_pkg::CH_SPACE && b != soifp_pkg::CH_TAB) begin
      if (p_name_cnt >= soifp_pkg::MAX_NAME_LEN) begin
        add_error(soifp_pkg::ERR_BAD_LINE);
      end else begin
        p_name_cnt++;
        p_brace_only = (p_name_cnt == 1 && b == soifp_pkg::CH_RBRACE);
        p_mode = soifp_pkg::MODE_NAME;
        fin = 1'b0;
      end
    end else if (b == soifp_pkg::CH_LBRACE && p_name_cnt != 0) begin
      p_mode = soifp_pkg::MODE_LEN0;
      p_remaining = '0;
      fin = 1'b0;
    end else if (b == soifp_pkg::CH_NL && p_brace_only && last) begin
      add_event(soifp_pkg::EV_COMPLETE, soifp_pkg::ERR_NONE, 1'b0, '0, '0, '0, '0);
    end else begin
      add_error(soifp_pkg::ERR_BAD_LINE);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic        fin;
    logic [2:0]  k;
    logic [31:0] acc;
    parse_out_t  po;
    fin = 1'b0;
    step_events.delete();
    if (p_mode == soifp_pkg::MODE_IGNORE) begin
      fin = 1'b1;
    end else if (p_offset >= soifp_pkg::MAX_RECORD_BYTES) begin
      add_error(soifp_pkg::ERR_BAD_LINE);
      fin = 1'b1;
    end else begin
      case (p_mode)
        soifp_pkg::MODE_LINE: begin
          p_name_begin = p_offset;
          p_name_cnt   = '0;
          p_brace_only = 1'b0;
          p_prefix     = '0;
          if (b == soifp_pkg::CH_AT) begin
            p_prefix   = 4'd1;
            p_name_cnt = 7'd1;
            p_mode     = soifp_pkg::MODE_HEAD;
          end else begin
            name_step(b, last, fin);
          end
        end
        soifp_pkg::MODE_HEAD: begin
          k = p_prefix[2:0];
          if (b == URL_HEAD[63 - 8 * k -: 8]) begin
            if (k < 5) p_name_cnt++;
            if (k == 3'd7) begin
              p_prefix      = 4'd8;
              p_value_begin = p_offset + 1'b1;
              p_mode        = soifp_pkg::MODE_URL;
            end else begin
              p_prefix = {1'b0, k} + 4'd1;
            end
          end else if (k >= 6) begin
            add_error(soifp_pkg::ERR_BAD_LINE);
            fin = 1'b1;
          end else begin
            p_mode = soifp_pkg::MODE_NAME;
            name_step(b, last, fin);
          end
        end
        soifp_pkg::MODE_NAME: name_step(b, last, fin);
        soifp_pkg::MODE_LEN0, soifp_pkg::MODE_LEN: begin
          if (b >= soifp_pkg::CH_ZERO && b <= soifp_pkg::CH_NINE) begin
            acc = {7'd0, p_remaining} * 32'd10 + {24'd0, b - soifp_pkg::CH_ZERO};
            if (acc > {7'd0, soifp_pkg::MAX_RECORD_BYTES}) begin
              acc = {7'd0, soifp_pkg::MAX_RECORD_BYTES};
            end
            p_remaining = acc[soifp_pkg::OFF_W-1:0];
            p_mode = soifp_pkg::MODE_LEN;
          end else if (b == soifp_pkg::CH_RBRACE && p_mode == soifp_pkg::MODE_LEN) begin
            p_mode = soifp_pkg::MODE_COLON;
          end else begin
            add_error(soifp_pkg::ERR_BAD_LINE);
            fin = 1'b1;
          end
        end
        soifp_pkg::MODE_COLON: begin
          if (b == soifp_pkg::CH_COLON) begin
            p_mode = soifp_pkg::MODE_TAB;
          end else begin
            add_error(soifp_pkg::ERR_BAD_LINE);
            fin = 1'b1;
          end
        end
        soifp_pkg::MODE_TAB: begin
          if (b == soifp_pkg::CH_TAB) begin
            p_value_begin = p_offset + 1'b1;
            p_mode = soifp_pkg::MODE_VALUE;
          end else begin
            add_error(soifp_pkg::ERR_BAD_LINE);
            fin = 1'b1;
          end
        end
        soifp_pkg::MODE_VALUE: begin
          if (p_remaining == 0) begin
            add_named_field(p_offset);
            if (b == soifp_pkg::CH_NL) begin
              p_mode = soifp_pkg::MODE_LINE;
            end else begin
              add_error(soifp_pkg::ERR_VALUE_NL);
              fin = 1'b1;
            end
          end else begin
            p_remaining--;
          end
        end
        soifp_pkg::MODE_URL: begin
          if (b == soifp_pkg::CH_NL) begin
            add_event(soifp_pkg::EV_FIELD, soifp_pkg::ERR_NONE, 1'b1, '0, '0,
                      p_value_begin, p_offset);
            p_mode = soifp_pkg::MODE_LINE;
          end
        end
        default: begin
          add_error(soifp_pkg::ERR_BAD_LINE);
          fin = 1'b1;
        end
      endcase
    end

    if (!fin && last) begin
      if (p_mode == soifp_pkg::MODE_LINE) begin
        add_event(soifp_pkg::EV_COMPLETE, soifp_pkg::ERR_NONE, 1'b0, '0, '0, '0, '0);
      end else if (p_mode == soifp_pkg::MODE_URL) begin
        add_error(soifp_pkg::ERR_URL_NL);
      end else if (p_mode == soifp_pkg::MODE_VALUE && p_remaining == 0) begin
        add_named_field(p_offset + 1'b1);
        add_error(soifp_pkg::ERR_VALUE_NL);
      end else begin
        add_error(soifp_pkg::ERR_BAD_LINE);
      end
    end

    foreach (step_events[i]) begin
      po.res      = step_events[i];
      po.run_last = (i == step_events.size() - 1);
      field_events_q.push_back(po);
    end

    if (last) begin
      clear_parser();
    end else begin
      if (fin) p_mode = soifp_pkg::MODE_IGNORE;
      if (p_offset < soifp_pkg::MAX_RECORD_BYTES) p_offset++;
    end
  endtask

  task automatic check_result();
    parse_out_t                  want;
    logic [soifp_pkg::OFF_W-1:0] got_v [8];
    logic [soifp_pkg::OFF_W-1:0] want_v [8];
    if (field_events_q.size() == 0) begin
      flag_error($sformatf("result with nothing pending: tuser %0h tdata %0h",
                           m_axis_tuser, m_axis_tdata));
    end else begin
      want = field_events_q.pop_front();
      got_v[0]  = {23'd0, m_axis_tuser[1:0]};
      got_v[1]  = {23'd0, m_axis_tdata[1:0]};
      got_v[2]  = {24'd0, m_axis_tuser[2]};
      got_v[3]  = m_axis_tdata[26:2];
      got_v[4]  = {18'd0, m_axis_tdata[33:27]};
      got_v[5]  = m_axis_tdata[58:34];
      got_v[6]  = m_axis_tdata[83:59];
      got_v[7]  = {24'd0, m_axis_tlast};
      want_v[0] = {23'd0, want.res.ev};
      want_v[1] = {23'd0, want.res.err};
      want_v[2] = {24'd0, want.res.is_url};
      want_v[3] = want.res.name_start;
      want_v[4] = {18'd0, want.res.name_length};
      want_v[5] = want.res.value_start;
      want_v[6] = want.res.value_end;
      want_v[7] = {24'd0, want.run_last};
      for (int i = 0; i < 8; i++) begin
        if (got_v[i] !== want_v[i]) begin
          flag_error($sformatf("%s is %0d, expected %0d", field_tag[i], got_v[i], want_v[i]));
        end
      end
    end
  endtask

  task automatic put_byte(input logic [7:0] d, input logic l);
    rec_byte_t rb;
    rb.data = d;
    rb.last = l;
    rb.hold = pause_pending;
    pause_pending = 1'b0;
    record_bytes_q.push_back(rb);
  endtask

  task automatic put_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], ends && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_name_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == soifp_pkg::CH_LBRACE || c == soifp_pkg::CH_COLON ||
               c == soifp_pkg::CH_NL || c == soifp_pkg::CH_SPACE ||
               c == soifp_pkg::CH_TAB);
    return c;
  endfunction

  task automatic random_record();
    logic [7:0] rec[$];
    int         lines;
    int         nlen;
    int         vlen;
    int         cut;
    int         pick;
    string      txt;
    lines = $urandom_range(0, 3);
    for (int l = 0; l < lines; l++) begin
      if ($urandom_range(0, 3) == 0) begin
        txt = "@FILE { ";
        for (int i = 0; i < txt.len(); i++) rec.push_back(txt[i]);
        vlen = $urandom_range(0, 10);
        for (int i = 0; i < vlen; i++) begin
          do pick = $urandom_range(0, 255); while (pick == soifp_pkg::CH_NL);
          rec.push_back(8'(pick));
        end
        rec.push_back(soifp_pkg::CH_NL);
      end else begin
        nlen = ($urandom_range(0, 40) == 0) ? $urandom_range(100, 127) : $urandom_range(1, 6);
        if ($urandom_range(0, 5) == 0) begin
          pick = $urandom_range(1, 5);
          for (int i = 0; i < pick; i++) rec.push_back(URL_HEAD[63 - 8 * i -: 8]);
        end
        for (int i = 0; i < nlen; i++) rec.push_back(pick_name_char());
        rec.push_back(soifp_pkg::CH_LBRACE);
        vlen = ($urandom_range(0, 20) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 10);
        if ($urandom_range(0, 7) == 0) begin
          txt = $sformatf("0%0d", vlen);
        end else begin
          txt = $sformatf("%0d", vlen);
        end
        for (int i = 0; i < txt.len(); i++) rec.push_back(txt[i]);
        rec.push_back(soifp_pkg::CH_RBRACE);
        rec.push_back(soifp_pkg::CH_COLON);
        rec.push_back(soifp_pkg::CH_TAB);
        for (int i = 0; i < vlen; i++) rec.push_back(8'($urandom_range(0, 255)));
        rec.push_back(soifp_pkg::CH_NL);
      end
    end
    if (rec.size() == 0 || $urandom_range(0, 3) != 0) begin
      rec.push_back(soifp_pkg::CH_RBRACE);
      rec.push_back(soifp_pkg::CH_NL);
    end
    case ($urandom_range(0, 9))
      0: rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        cut = $urandom_range(1, rec.size());
        while (rec.size() > cut) void'(rec.pop_back());
      end
      2: rec.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
    foreach (rec[i]) put_byte(rec[i], i == rec.size() - 1);
  endtask

  always @(posedge clk_i) begin : drive_proc
    logic      calm;
    rec_byte_t nb;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) quiet <= !quiet;
      calm = quiet || record_bytes_q.size() < 120;

      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end

      if (!s_axis_tvalid || s_axis_tready) begin
        if (draining) begin
          if (field_events_q.size() == 0) draining <= 1'b0;
          s_axis_tvalid <= 1'b0;
        end else if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (record_bytes_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (record_bytes_q[0].hold) begin
          record_bytes_q[0].hold = 1'b0;
          draining <= 1'b1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(0, 14);
          s_axis_tvalid <= 1'b0;
        end else begin
          nb = record_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nb.data;
          s_axis_tlast  <= nb.last;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    clear_parser();

    put_text("}\n", 1);
    put_text("@FILE { u\n", 1);
    put_text("@FILE { ab", 1);
    put_text("a{1}:\tx", 1);
    put_text("ab{5}:\tx", 1);
    put_text("b{0}:\tZ\n", 1);
    put_text("}\nx", 1);
    put_text("}", 1);
    put_text("\n", 1);
    put_text("{1}:\t\n", 1);
    put_text("c{}", 1);
    put_text("d{ 1}", 1);
    put_text("e{+1}", 1);
    put_text("f{99999999999}:\tq\n", 1);
    put_text("g{2}:\t", 0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_text("\n", 1);
    put_byte(8'h00, 1'b0);
    put_text("{0}:\t\n}\n", 1);
    put_text("@FX{1}:\tv\n}\n", 1);
    put_text("@FILE {x", 1);
    put_text("h{3}:\t}\n:\n}\n", 1);
    for (int i = 0; i < 127; i++) put_byte(8'hFF, 1'b0);
    put_text("{0}:\t\n", 1);
    for (int i = 0; i < 128; i++) put_byte(8'h80, i == 127);

    while (record_bytes_q.size() < RANDOM_BYTES) begin
      if (!paused && record_bytes_q.size() > RANDOM_BYTES / 2) begin
        pause_pending = 1'b1;
        paused = 1'b1;
      end
      random_record();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(record_bytes_q.size() == 0 && !s_axis_tvalid && field_events_q.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
    end

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (20) @(negedge clk_i);
      if (mismatch_count == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
